>>> sv/byte_pattern_search_macros.svh
// Assertion macros used by the byte pattern search RTL.
`ifndef BYTE_PATTERN_SEARCH_MACROS_SVH
`define BYTE_PATTERN_SEARCH_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on every rising edge outside reset.
`define BPS_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define BPS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Condition that must never hold.
`define BPS_ASSERT_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error(msg);

`else

`define BPS_ASSERT_IMPL(label, ante, cons, msg)
`define BPS_ASSERT_NEXT(label, ante, cons, msg)
`define BPS_ASSERT_NEVER(label, cond, msg)

`endif

`endif

>>> sv/bps_pkg.sv
// Package with the constants, types and helpers of the byte pattern search.
`timescale 1ns / 1ps
`default_nettype none
package bps_pkg;

   localparam int MAX_PATTERN_BYTES = 16;
   localparam int POSITION_BITS     = 20;
   localparam int FIELD_POS_BITS    = 20;
   localparam int START_BITS        = 20;
   localparam int PAT_LEN_BITS      = 5;
   localparam int CSR_INDEX_BITS    = 8;
   localparam int CSR_DATA_BITS     = 64;

   localparam int LEN_BITS = $clog2(MAX_PATTERN_BYTES + 1);
   localparam int IDX_BITS = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;
   localparam int CMP_BITS = (POSITION_BITS > FIELD_POS_BITS) ? POSITION_BITS : FIELD_POS_BITS;
   localparam int RSP_DATA_BITS = ((FIELD_POS_BITS + 7) / 8) * 8;

   localparam logic [POSITION_BITS-1:0]  POS_MAX       = '1;
   localparam logic [FIELD_POS_BITS-1:0] FIELD_POS_MAX = '1;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_PATTERN_LO  = 8'd0,
      CSR_PATTERN_HI  = 8'd1,
      CSR_PATTERN_LEN = 8'd2,
      CSR_START_OFS   = 8'd3
   } csr_reg_type;

   // Control that the top level hands to every cell of the window.
   typedef struct packed {
      logic shift;
      logic in_use;
   } bps_cell_ctl_type;

   // Byte idx of the 16-byte pattern held in two 64-bit registers.
   function automatic logic [7:0] pattern_byte(input logic [63:0] lo,
                                               input logic [63:0] hi,
                                               input logic [3:0]  idx);
      logic [127:0] all;
      begin
         all = {hi, lo};
         pattern_byte = all[{idx, 3'b000} +: 8];
      end
   endfunction

endpackage
`default_nettype wire

>>> sv/bps_cell.sv
// One window cell: holds a buffer byte, compares its incoming byte, passes it on.
`timescale 1ns / 1ps
`default_nettype none
module bps_cell
   import bps_pkg::*;
(
   input  wire logic             clock,
   input  wire bps_cell_ctl_type ctl,
   input  wire logic [7:0]       byte_in,
   input  wire logic [7:0]       pat_byte,
   output logic      [7:0]       byte_out,
   output logic                  match
);

   logic [7:0] byte_ff;
   logic [7:0] byte_next_in;

   // The compare looks at the byte this cell will hold after the shift.
   assign match    = !ctl.in_use || (byte_in == pat_byte);
   assign byte_out = byte_ff;

   always_comb begin
      byte_next_in = ctl.shift ? byte_in : byte_ff;
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_next_in;
   end

endmodule
`default_nettype wire

>>> sv/byte_pattern_search.sv
// Top level of the streaming byte pattern search.
//
//  channel  direction  tdata / data                 side band
//  req_     in         [7:0] data_byte              tlast: last_byte
//  rsp_     out        [19:0] match_position        tuser: found
//  csr_     in         csr_index, [63:0] csr_data   -
//
// One byte is taken every cycle while req_tready is high; the window of cells shifts
// and compares in the same cycle, so a byte's result is loaded into the output register as the byte is taken.
// req_tready falls only while a result waits in the output register unaccepted.
// Reset clears the buffer state and the output valid flag and restores the configuration.
// The byte window needs no clearing: a match needs as many bytes of this buffer.
`timescale 1ns / 1ps
`default_nettype none
`include "byte_pattern_search_macros.svh"
module byte_pattern_search
   import bps_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   input  wire logic [7:0]                req_tdata,   // [7:0] data_byte
   input  wire logic                      req_tlast,
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   output logic      [RSP_DATA_BITS-1:0]  rsp_tdata,   // [19:0] match_position
   output logic                           rsp_tuser,   // [0] found
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_data
);

   logic [63:0]               pat_lo_ff;
   logic [63:0]               pat_hi_ff;
   logic [PAT_LEN_BITS-1:0]   pat_len_ff;
   logic [START_BITS-1:0]     start_ff;

   logic [POSITION_BITS-1:0]  pos_ff, pos_in;
   logic [LEN_BITS-1:0]       since_ff, since_in, since_step;
   logic                      done_ff, done_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_found_ff, rsp_found_in;
   logic [FIELD_POS_BITS-1:0] rsp_pos_ff, rsp_pos_in;

   logic                      accept;
   logic                      work;
   logic                      hit;
   logic                      load_rsp;
   logic [LEN_BITS-1:0]       len_eff;
   logic [POSITION_BITS-1:0]  match_base;
   logic [FIELD_POS_BITS-1:0] match_pos;

   logic [7:0]                chain [MAX_PATTERN_BYTES+1];
   logic [MAX_PATTERN_BYTES-1:0] cell_match;

   assign accept     = req_tvalid && req_tready;
   assign work       = accept && !done_ff;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign csr_ready  = 1'b1;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_found_ff;
   assign rsp_tdata  = RSP_DATA_BITS'(rsp_pos_ff);

   // Length zero reads as one, lengths above the window as the full window.
   always_comb begin
      if (pat_len_ff == '0) begin
         len_eff = LEN_BITS'(1);
      end else if (pat_len_ff > PAT_LEN_BITS'(MAX_PATTERN_BYTES)) begin
         len_eff = LEN_BITS'(MAX_PATTERN_BYTES);
      end else begin
         len_eff = pat_len_ff[LEN_BITS-1:0];
      end
   end

   // Cell j holds the byte j places back and checks it against pattern byte
   // len - 1 - j, so the newest byte meets the last pattern byte.
   assign chain[0] = req_tdata;

   for (genvar j = 0; j < MAX_PATTERN_BYTES; j++) begin : g_cell
      logic [LEN_BITS-1:0] pat_idx;
      bps_cell_ctl_type    ctl;
      logic [7:0]          pat_sel;

      assign pat_idx    = len_eff - LEN_BITS'(j + 1);
      assign ctl.shift  = work;
      assign ctl.in_use = LEN_BITS'(j) < len_eff;
      assign pat_sel    = pattern_byte(pat_lo_ff, pat_hi_ff, 4'(pat_idx[IDX_BITS-1:0]));

      bps_cell u_cell (
         .clock    (clock),
         .ctl      (ctl),
         .byte_in  (chain[j]),
         .pat_byte (pat_sel),
         .byte_out (chain[j+1]),
         .match    (cell_match[j])
      );
   end

   always_comb begin
      since_step = since_ff;
      if ((CMP_BITS'(pos_ff) >= CMP_BITS'(start_ff)) &&
          (since_ff < LEN_BITS'(MAX_PATTERN_BYTES))) begin
         since_step = since_ff + LEN_BITS'(1);
      end
      hit        = (since_step >= len_eff) && (&cell_match);
      match_base = pos_ff - POSITION_BITS'(len_eff) + POSITION_BITS'(1);
      if (CMP_BITS'(match_base) > CMP_BITS'(FIELD_POS_MAX)) begin
         match_pos = FIELD_POS_MAX;
      end else begin
         match_pos = FIELD_POS_BITS'(match_base);
      end
   end

   always_comb begin
      pos_in       = pos_ff;
      since_in     = since_ff;
      done_in      = done_ff;
      load_rsp     = 1'b0;
      rsp_found_in = rsp_found_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      if (work) begin
         if (pos_ff < POS_MAX) begin
            pos_in = pos_ff + POSITION_BITS'(1);
         end
         since_in = since_step;
         if (hit) begin
            load_rsp     = 1'b1;
            rsp_found_in = 1'b1;
            rsp_pos_in   = match_pos;
            done_in      = 1'b1;
         end else if (req_tlast) begin
            load_rsp     = 1'b1;
            rsp_found_in = 1'b0;
            rsp_pos_in   = '0;
         end
      end

      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end

      // The final byte of a buffer always starts the next one afresh.
      if (accept && req_tlast) begin
         pos_in   = '0;
         since_in = '0;
         done_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         since_ff     <= '0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         since_ff     <= since_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_found_ff <= rsp_found_in;
      rsp_pos_ff   <= rsp_pos_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_lo_ff  <= '0;
         pat_hi_ff  <= '0;
         pat_len_ff <= PAT_LEN_BITS'(1);
         start_ff   <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_PATTERN_LO:  pat_lo_ff  <= csr_data[63:0];
            CSR_PATTERN_HI:  pat_hi_ff  <= csr_data[63:0];
            CSR_PATTERN_LEN: pat_len_ff <= csr_data[PAT_LEN_BITS-1:0];
            CSR_START_OFS:   start_ff   <= csr_data[START_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   `BPS_ASSERT_IMPL(a_not_found_pos_zero, rsp_tvalid && !rsp_tuser, rsp_tdata == '0, "not-found result carries a non-zero position")
   `BPS_ASSERT_NEXT(a_last_clears_buffer, accept && req_tlast, (pos_ff == '0) && (since_ff == '0) && !done_ff, "buffer state not cleared after the final beat")
   `BPS_ASSERT_IMPL(a_done_no_result, accept && done_ff, !load_rsp, "second result produced for one buffer")
   `BPS_ASSERT_NEVER(a_since_bound, since_ff > LEN_BITS'(MAX_PATTERN_BYTES), "byte count beyond the window size")

endmodule
`default_nettype wire

>>> verif/bps_match_checker.sv
// Checker for the byte pattern search: watches all three channels, predicts and compares.
`timescale 1ns / 1ps
module bps_match_checker
   import bps_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   input  wire logic                      req_tready,
   input  wire logic [7:0]                req_tdata,   // [7:0] data_byte
   input  wire logic                      req_tlast,
   input  wire logic                      rsp_tvalid,
   input  wire logic                      rsp_tready,
   input  wire logic [RSP_DATA_BITS-1:0]  rsp_tdata,   // [19:0] match_position
   input  wire logic                      rsp_tuser,   // [0] found
   input  wire logic                      csr_valid,
   input  wire logic                      csr_ready,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_data,
   output int                             outstanding,
   output int                             errors
);

   typedef struct packed {
      logic                      found;
      logic [FIELD_POS_BITS-1:0] position;
   } search_result_type;

   search_result_type pending_matches[$];

   logic [63:0]               pattern_lo;
   logic [63:0]               pattern_hi;
   logic [PAT_LEN_BITS-1:0]   pattern_len;
   logic [START_BITS-1:0]     start_ofs;

   logic [7:0]                window [MAX_PATTERN_BYTES];
   logic [POSITION_BITS-1:0]  next_pos;
   int                        since_start;
   bit                        result_given;

   task automatic clear_buffer();
      int i;
      for (i = 0; i < MAX_PATTERN_BYTES; i++) window[i] = 8'h00;
      next_pos     = '0;
      since_start  = 0;
      result_given = 1'b0;
   endtask

   task automatic predict_byte(input logic [7:0] b, input logic final_beat);
      logic [POSITION_BITS-1:0] cur;
      logic [127:0]             pat;
      int                       span;
      int                       i;
      bit                       hit;
      int unsigned              lead;
      search_result_type        res;
      // Once a buffer has its result, the rest of it is skipped up to the final beat.
      if (result_given) begin
         if (final_beat) clear_buffer();
         return;
      end
      cur = next_pos;
      if (next_pos != POS_MAX) next_pos = next_pos + POSITION_BITS'(1);
      for (i = MAX_PATTERN_BYTES - 1; i > 0; i--) window[i] = window[i-1];
      window[0] = b;
      if (cur >= start_ofs && since_start < MAX_PATTERN_BYTES) since_start++;

      span = int'(pattern_len);
      if (span == 0) span = 1;
      if (span > MAX_PATTERN_BYTES) span = MAX_PATTERN_BYTES;
      pat = {pattern_hi, pattern_lo};
      hit = (since_start >= span);
      for (i = 0; hit && i < span; i++) begin
         if (window[span-1-i] != pat[8*i +: 8]) hit = 1'b0;
      end

      if (hit) begin
         lead = int'(cur) - (span - 1);
         if (lead > int'(FIELD_POS_MAX)) lead = int'(FIELD_POS_MAX);
         res.found    = 1'b1;
         res.position = lead[FIELD_POS_BITS-1:0];
         pending_matches.push_back(res);
         if (final_beat) clear_buffer();
         else result_given = 1'b1;
      end else if (final_beat) begin
         res.found    = 1'b0;
         res.position = '0;
         pending_matches.push_back(res);
         clear_buffer();
      end
   endtask

   always @(posedge clock) begin : watch
      search_result_type         want;
      logic [RSP_DATA_BITS-1:0]  want_data;
      if (reset) begin
         pattern_lo  = '0;
         pattern_hi  = '0;
         pattern_len = PAT_LEN_BITS'(1);
         start_ofs   = '0;
         clear_buffer();
         pending_matches.delete();
         errors = 0;
      end else begin
         // Results are taken first, so a result cannot be matched to a byte of the same edge.
         if (rsp_tvalid && rsp_tready) begin
            if (pending_matches.size() == 0) begin
               errors++;
               $display("%0t: unexpected result beat: expected none, got found=%0b pos=%0h",
                        $time, rsp_tuser, rsp_tdata);
            end else begin
               want      = pending_matches.pop_front();
               want_data = RSP_DATA_BITS'(want.position);
               if (rsp_tuser !== want.found) begin
                  errors++;
                  $display("%0t: found flag mismatch: expected %0b, got %0b",
                           $time, want.found, rsp_tuser);
               end
               if (rsp_tdata !== want_data) begin
                  errors++;
                  $display("%0t: match position mismatch: expected %0h, got %0h",
                           $time, want_data, rsp_tdata);
               end
            end
         end
         if (req_tvalid && req_tready) predict_byte(req_tdata, req_tlast);
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_PATTERN_LO:  pattern_lo  = csr_data;
               CSR_PATTERN_HI:  pattern_hi  = csr_data;
               CSR_PATTERN_LEN: pattern_len = csr_data[PAT_LEN_BITS-1:0];
               CSR_START_OFS:   start_ofs   = csr_data[START_BITS-1:0];
               default: ;
            endcase
         end
      end
      outstanding <= pending_matches.size();
   end

endmodule

>>> verif/tb_byte_pattern_search.sv
// Testbench top for the byte pattern search: clock, reset, stimulus and the verdict.
`timescale 1ns / 1ps
module tb_byte_pattern_search
   import bps_pkg::*;
();

   localparam int CLOCK_PERIOD      = 20;
   localparam int RESET_CYCLES      = 7;
   localparam int IDLE_PCT          = 14;
   localparam int SETTLE_CYCLES     = 4;
   localparam int RANDOM_BYTES      = 950;
   localparam int BUFFERS_PER_PHASE = 6;
   localparam int TIMEOUT_NS        = 2_000_000;
   localparam logic [7:0] ALPHA_BASE = 8'h61;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FIRST_UNUSED = 8'd4;

   logic                      clock      = 1'b0;
   logic                      reset      = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [7:0]                req_tdata  = 8'h00;   // [7:0] data_byte
   logic                      req_tlast  = 1'b0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0]  rsp_tdata;            // [19:0] match_position
   logic                      rsp_tuser;            // [0] found
   logic                      csr_valid  = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index  = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data   = '0;
   int                        outstanding;
   int                        errors;

   // Copy of the registers as written, used only to shape the stimulus.
   logic [63:0]               pat_lo    = '0;
   logic [63:0]               pat_hi    = '0;
   logic [PAT_LEN_BITS-1:0]   pat_len   = PAT_LEN_BITS'(1);
   logic [START_BITS-1:0]     start_ofs = '0;
   bit                        quiet      = 1'b0;
   bit                        alpha_mode = 1'b0;
   int                        searched   = 0;

   byte_pattern_search u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   bps_match_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .outstanding (outstanding),
      .errors      (errors)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      rsp_tready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
   end

   initial begin
      #(TIMEOUT_NS);
      $display("RESULT: ERROR");
      $finish;
   end

   // Small alphabets make partial and overlapping matches common.
   function automatic logic [7:0] rand_byte();
      logic [7:0] b;
      if (alpha_mode) b = ALPHA_BASE + 8'($urandom_range(0, 2));
      else b = 8'($urandom());
      return b;
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic final_beat);
      csr_valid <= 1'b0;
      while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= final_beat;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx, input logic [63:0] v);
      while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
         csr_valid <= 1'b0;
         @(posedge clock);
      end
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_PATTERN_LO:  pat_lo    = v;
         CSR_PATTERN_HI:  pat_hi    = v;
         CSR_PATTERN_LEN: pat_len   = v[PAT_LEN_BITS-1:0];
         CSR_START_OFS:   start_ofs = v[START_BITS-1:0];
         default: ;
      endcase
   endtask

   // Stops both senders and waits until every result has been taken.
   task automatic settle();
      req_tvalid <= 1'b0;
      csr_valid  <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin : stimulus
      int           i;
      int           k;
      int           phase;
      int           span;
      int           blen;
      int           at;
      bit           embed;
      bit           broken;
      logic [7:0]   b;
      logic [63:0]  v;
      logic [127:0] pat;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Single-character search with the reset settings, matching on the final beat.
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b1);
      settle();

      // A length of zero behaves as one; this buffer holds no match.
      write_reg(CSR_PATTERN_LEN, 64'd0);
      write_reg(CSR_PATTERN_LO, 64'h0000_0000_0000_00FF);
      send_byte(8'h00, 1'b1);
      settle();

      // A length above the window is clipped to the full sixteen bytes.
      write_reg(CSR_PATTERN_LO, {$urandom(), $urandom()});
      write_reg(CSR_PATTERN_HI, {$urandom(), $urandom()});
      write_reg(CSR_PATTERN_LEN, 64'd31);
      pat = {pat_hi, pat_lo};
      for (i = 0; i < MAX_PATTERN_BYTES; i++) send_byte(pat[8*i +: 8], i == MAX_PATTERN_BYTES - 1);
      settle();

      // Start offset at its top value: nothing in a short buffer can match.
      write_reg(CSR_PATTERN_LEN, 64'd1);
      write_reg(CSR_PATTERN_LO, 64'd0);
      v = '0;
      v[START_BITS-1:0] = '1;
      write_reg(CSR_START_OFS, v);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b1);
      settle();

      write_reg(CSR_FIRST_UNUSED, '1);

      // Settings changed in the middle of a buffer, then bytes after the match are skipped.
      write_reg(CSR_START_OFS, 64'd0);
      write_reg(CSR_PATTERN_LEN, 64'd2);
      write_reg(CSR_PATTERN_LO, 64'h4241);
      send_byte(8'h41, 1'b0);
      settle();
      write_reg(CSR_PATTERN_LEN, 64'd1);
      write_reg(CSR_PATTERN_LO, 64'h5A);
      send_byte(8'h5A, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);

      phase = 0;
      while (searched < RANDOM_BYTES) begin
         quiet = (phase >= 3 && phase <= 5);
         settle();
         alpha_mode = ($urandom_range(0, 2) != 0);
         for (i = 0; i < 16; i++) pat[8*i +: 8] = rand_byte();
         if (phase == 0 || alpha_mode || $urandom_range(0, 1)) write_reg(CSR_PATTERN_LO, pat[63:0]);
         if (phase == 0 || alpha_mode || $urandom_range(0, 1)) write_reg(CSR_PATTERN_HI, pat[127:64]);

         v = {$urandom(), $urandom()};
         case ($urandom_range(0, 9))
            0:       v[PAT_LEN_BITS-1:0] = '0;
            1:       v[PAT_LEN_BITS-1:0] = PAT_LEN_BITS'($urandom_range(MAX_PATTERN_BYTES + 1, 31));
            2:       v[PAT_LEN_BITS-1:0] = PAT_LEN_BITS'(MAX_PATTERN_BYTES);
            default: v[PAT_LEN_BITS-1:0] = PAT_LEN_BITS'($urandom_range(1, MAX_PATTERN_BYTES));
         endcase
         if (phase == 0 || $urandom_range(0, 3) != 0) write_reg(CSR_PATTERN_LEN, v);

         v = {$urandom(), $urandom()};
         case ($urandom_range(0, 9))
            0:       v[START_BITS-1:0] = '1;
            1:       ;
            2, 3:    v[START_BITS-1:0] = '0;
            default: v[START_BITS-1:0] = START_BITS'($urandom_range(1, 12));
         endcase
         if (phase == 0 || $urandom_range(0, 2) == 0) write_reg(CSR_START_OFS, v);
         if ($urandom_range(0, 4) == 0)
            write_reg(CSR_FIRST_UNUSED + CSR_INDEX_BITS'($urandom_range(0, 251)),
                      {$urandom(), $urandom()});

         pat  = {pat_hi, pat_lo};
         span = (pat_len == 0) ? 1 :
                ((pat_len > MAX_PATTERN_BYTES) ? MAX_PATTERN_BYTES : int'(pat_len));
         for (k = 0; k < BUFFERS_PER_PHASE; k++) begin
            blen   = $urandom_range(1, 40);
            embed  = ($urandom_range(0, 9) < 6);
            broken = embed && ($urandom_range(0, 3) == 0);
            at     = $urandom_range(0, 8) + ((start_ofs < 32) ? int'(start_ofs) : 0);
            if (embed && blen < at + span) blen = at + span + $urandom_range(0, 3);
            for (i = 0; i < blen; i++) begin
               b = rand_byte();
               if (embed && i >= at && i < at + span) begin
                  b = pat[8*(i-at) +: 8];
                  // A spoilt final byte leaves a near miss in place of the match.
                  if (broken && i == at + span - 1) b = ~b;
               end
               send_byte(b, i == blen - 1);
               searched++;
            end
         end
         phase++;
      end
      settle();

      if (errors == 0 && outstanding == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

>>> byte_pattern_search.f
+incdir+sv
sv/bps_pkg.sv
sv/bps_cell.sv
sv/byte_pattern_search.sv
verif/bps_match_checker.sv
verif/tb_byte_pattern_search.sv
